[rtl/nmf_pkg.sv]
package nmf_pkg;

    // Pixel and result formats
    localparam int PIXEL_BITS = 16;
    localparam int MEAN_W     = 24;
    localparam int POS_W      = 10;

    // Configuration register width and defaults
    localparam int CFG_W        = 11;
    localparam int ROW_W        = CFG_W + 1;
    localparam int MAX_ROWS     = 1024;
    localparam int MAX_COLS_DEF = 1024;

    // Neighbor count codes
    localparam logic [1:0] DIV_3 = 2'd0;
    localparam logic [1:0] DIV_5 = 2'd1;
    localparam logic [1:0] DIV_8 = 2'd2;

    // Partial and total sum widths
    localparam int PSA_W = PIXEL_BITS + 2;
    localparam int PSB_W = PIXEL_BITS + 3;
    localparam int SUM_W = PIXEL_BITS + 4;

    // Division by 3 or 5 through a reciprocal: the biased dividend stays positive
    localparam int Y_OFS_EXP = 24;
    localparam int Y_W       = 27;
    localparam int RECIP_W   = 31;
    localparam int RECIP_SH  = 32;
    localparam int PROD_W    = Y_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'(((64'd1 << RECIP_SH) + 64'd2) / 64'd3);
    localparam logic [RECIP_W-1:0] RECIP_5 = RECIP_W'(((64'd1 << RECIP_SH) + 64'd4) / 64'd5);

endpackage

[rtl/nmf_ram.sv]
module nmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; a read at the written address sees old data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/neighbour_mean_3x3_filter.sv]
// 3x3 neighbor mean filter, center excluded, over a streamed signed matrix.
// Input channel (in_valid/in_ready, op, pixel): op = 0 brings the next pixel
// in row-major order, op = 1 is a drain item. After the last pixel of the
// matrix, column_count + 1 drain items flush the remaining results. Drain
// items before the matrix end and pixels after it are taken and dropped.
// Output channel (out_valid/out_ready): mean_q8 is the mean times 256,
// floored, with its out_row/out_col position; last marks the final result,
// after which the next pixel starts a new matrix.
// Throughput: one item per clock while in_ready is high. The two line stores
// share one memory, read and written back at one column per cycle unless
// stalled. A result passes the stage 1, 2 and 3 registers and the output
// register; results lag the pixel stream by one row plus one pixel.
// An output register plus a skid register part the sides, so one item is
// still taken while a result waits; in_ready drops once both are full.
// Configuration (APB, row_count at 0x0, column_count at 0x4) is to be written
// only while idle (the block does not check this) and restarts the matrix.
// Reset: counts to 2, pipeline emptied, line store undefined until written.
module neighbour_mean_3x3_filter
    import nmf_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Input channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         op,
    input  logic signed [PIXEL_BITS-1:0] pixel,
    // Output channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [MEAN_W-1:0]     mean_q8,
    output logic [POS_W-1:0]             out_row,
    output logic [POS_W-1:0]             out_col,
    output logic                         last,
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int ADDR_W = $clog2(MAX_COLS);
    localparam int P      = PIXEL_BITS;

    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    // Configuration and raster counters
    logic [CFG_W-1:0] row_count_reg, column_count_reg;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CFG_W-1:0] col_reg, col_next;

    logic             cfg_wr;
    logic [CFG_W-1:0] cfg_val;
    logic [CFG_W-1:0] cfg_rows, cfg_cols;

    // Stage 0 decode
    logic             accept, in_matrix, effective;
    logic             emit_right, emit_main, emit;
    logic [ROW_W-1:0] orow;
    logic [CFG_W-1:0] ocol;
    logic             top_ok, bot_ok, left_ok, right_ok, is_last;
    logic [2:0]       nflags;
    logic [1:0]       div_code;
    logic [CFG_W-1:0] col_inc;
    logic [ADDR_W-1:0] rd_addr;

    // Stage 1
    logic              s1_valid_reg, s1_emit_reg, s1_last_reg;
    logic signed [P-1:0] s1_pix_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [7:0]        s1_mask_reg;
    logic [1:0]        s1_div_reg;
    logic [POS_W-1:0]  s1_row_reg, s1_col_reg;

    logic [2*P-1:0]    ram_rdata, rd_data, wr_data;
    logic              fwd_hit_reg;
    logic [2*P-1:0]    fwd_data_reg;
    logic signed [P-1:0] up_f, mid_f;
    logic signed [P-1:0] win0_reg [3];
    logic signed [P-1:0] win1_reg [3];
    logic signed [P-1:0] term [8];
    logic signed [PSA_W-1:0] ps_a;
    logic signed [PSB_W-1:0] ps_b;

    // Stage 2
    logic              s2_valid_reg, s2_last_reg;
    logic signed [PSA_W-1:0] s2_psa_reg;
    logic signed [PSB_W-1:0] s2_psb_reg;
    logic [1:0]        s2_div_reg;
    logic [POS_W-1:0]  s2_row_reg, s2_col_reg;
    logic signed [SUM_W-1:0] sum;
    logic signed [Y_W:0] y_biased;

    // Stage 3
    logic              s3_valid_reg, s3_last_reg;
    logic [Y_W-1:0]    s3_y_reg;
    logic [MEAN_W-1:0] s3_mean8_reg;
    logic [1:0]        s3_div_reg;
    logic [POS_W-1:0]  s3_row_reg, s3_col_reg;
    logic [PROD_W-1:0] prod;
    logic [MEAN_W-1:0] res_mean;

    // Output and skid registers
    logic              en;
    logic              out_valid_reg, skid_valid_reg;
    logic [MEAN_W-1:0] out_mean_reg, skid_mean_reg;
    logic [POS_W-1:0]  out_row_reg, out_col_reg, skid_row_reg, skid_col_reg;
    logic              out_last_reg, skid_last_reg;
    logic              pop;

    // Configuration write and read
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_val = pwdata[CFG_W-1:0];

    always_comb
    begin
        cfg_rows = cfg_val;
        if (cfg_val < CFG_W'(2))
        begin
            cfg_rows = CFG_W'(2);
        end
        else if (cfg_val > MAX_ROWS)
        begin
            cfg_rows = CFG_W'(MAX_ROWS);
        end
        cfg_cols = cfg_val;
        if (cfg_val < CFG_W'(2))
        begin
            cfg_cols = CFG_W'(2);
        end
        else if (cfg_val > MAX_COLS)
        begin
            cfg_cols = CFG_W'(MAX_COLS);
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_ROW_COUNT: prdata = {{(32-CFG_W){1'b0}}, row_count_reg};
            REG_COL_COUNT: prdata = {{(32-CFG_W){1'b0}}, column_count_reg};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= CFG_W'(2);
            column_count_reg <= CFG_W'(2);
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_ROW_COUNT: row_count_reg    <= cfg_rows;
                REG_COL_COUNT: column_count_reg <= cfg_cols;
                default:       row_count_reg    <= row_count_reg;
            endcase
        end
    end

    // Decode the accepted item against the raster position
    assign en       = !skid_valid_reg;
    assign in_ready = en;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        in_matrix  = row_reg < ROW_W'(row_count_reg);
        effective  = op ? !in_matrix : in_matrix;
        emit_right = (col_reg == '0) && (row_reg >= ROW_W'(2));
        emit_main  = (col_reg != '0) && (row_reg != '0);
        emit       = effective && (emit_right || emit_main);
        if (emit_right)
        begin
            orow = row_reg - ROW_W'(2);
            ocol = column_count_reg - CFG_W'(1);
        end
        else
        begin
            orow = row_reg - ROW_W'(1);
            ocol = col_reg - CFG_W'(1);
        end
        top_ok   = orow != '0;
        bot_ok   = (orow + ROW_W'(1)) < ROW_W'(row_count_reg);
        left_ok  = ocol != '0;
        right_ok = (ocol + CFG_W'(1)) < column_count_reg;
        is_last  = (orow == ROW_W'(row_count_reg) - ROW_W'(1))
                && (ocol == column_count_reg - CFG_W'(1));
        nflags   = 3'(top_ok) + 3'(bot_ok) + 3'(left_ok) + 3'(right_ok);
        case (nflags)
            3'd4:    div_code = DIV_8;
            3'd3:    div_code = DIV_5;
            default: div_code = DIV_3;
        endcase
        rd_addr = ADDR_W'(col_reg);
    end

    // Advance the raster counters
    always_comb
    begin
        col_inc  = col_reg + CFG_W'(1);
        row_next = row_reg;
        col_next = col_reg;
        if (cfg_wr)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (accept && effective)
        begin
            if (emit && is_last)
            begin
                row_next = '0;
                col_next = '0;
            end
            else if (col_inc >= column_count_reg)
            begin
                row_next = row_reg + ROW_W'(1);
                col_next = '0;
            end
            else
            begin
                col_next = col_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // Line store: {upper, middle} per column
    nmf_ram #(
        .WIDTH (2*P),
        .DEPTH (MAX_COLS)
    ) u_line_ram (
        .clk   (clk),
        .we    (en && s1_valid_reg),
        .waddr (s1_addr_reg),
        .wdata (wr_data),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= accept && effective;
            s1_emit_reg  <= accept && emit;
            if (accept)
            begin
                fwd_hit_reg <= s1_valid_reg && (s1_addr_reg == rd_addr);
            end
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg   <= op ? '0 : pixel;
            s1_addr_reg  <= rd_addr;
            s1_mask_reg  <= {bot_ok && right_ok, bot_ok, bot_ok && left_ok, right_ok,
                             left_ok, top_ok && right_ok, top_ok, top_ok && left_ok};
            s1_div_reg   <= div_code;
            s1_row_reg   <= orow[POS_W-1:0];
            s1_col_reg   <= ocol[POS_W-1:0];
            s1_last_reg  <= is_last;
            fwd_data_reg <= wr_data;
        end
    end

    // Stage 1: fresh column, write back, masked partial sums
    always_comb
    begin
        rd_data = fwd_hit_reg ? fwd_data_reg : ram_rdata;
        up_f    = rd_data[2*P-1:P];
        mid_f   = rd_data[P-1:0];
        wr_data = {mid_f, s1_pix_reg};
        term[0] = s1_mask_reg[0] ? win0_reg[0] : '0;
        term[1] = s1_mask_reg[1] ? win1_reg[0] : '0;
        term[2] = s1_mask_reg[2] ? up_f        : '0;
        term[3] = s1_mask_reg[3] ? win0_reg[1] : '0;
        term[4] = s1_mask_reg[4] ? mid_f       : '0;
        term[5] = s1_mask_reg[5] ? win0_reg[2] : '0;
        term[6] = s1_mask_reg[6] ? win1_reg[2] : '0;
        term[7] = s1_mask_reg[7] ? s1_pix_reg  : '0;
        ps_a = PSA_W'(term[0]) + PSA_W'(term[1]) + PSA_W'(term[2]);
        ps_b = PSB_W'(term[3]) + PSB_W'(term[4]) + PSB_W'(term[5])
             + PSB_W'(term[6]) + PSB_W'(term[7]);
    end

    // Shift the window by one column
    always_ff @(posedge clk)
    begin
        if (en && s1_valid_reg)
        begin
            win0_reg[0] <= win1_reg[0];
            win0_reg[1] <= win1_reg[1];
            win0_reg[2] <= win1_reg[2];
            win1_reg[0] <= up_f;
            win1_reg[1] <= mid_f;
            win1_reg[2] <= s1_pix_reg;
        end
    end

    // Stage 2 through stage 3 pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_emit_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_comb
    begin
        sum      = SUM_W'(s2_psa_reg) + SUM_W'(s2_psb_reg);
        y_biased = ((Y_W+1)'(sum) <<< 8)
                 + ((s2_div_reg == DIV_5) ? (Y_W+1)'(5 << Y_OFS_EXP)
                                          : (Y_W+1)'(3 << Y_OFS_EXP));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_psa_reg   <= ps_a;
            s2_psb_reg   <= ps_b;
            s2_div_reg   <= s1_div_reg;
            s2_row_reg   <= s1_row_reg;
            s2_col_reg   <= s1_col_reg;
            s2_last_reg  <= s1_last_reg;
            s3_y_reg     <= y_biased[Y_W-1:0];
            s3_mean8_reg <= {sum[MEAN_W-6:0], 5'b0};
            s3_div_reg   <= s2_div_reg;
            s3_row_reg   <= s2_row_reg;
            s3_col_reg   <= s2_col_reg;
            s3_last_reg  <= s2_last_reg;
        end
    end

    // Stage 3: reciprocal multiply; the bias drops out above the result bits
    always_comb
    begin
        prod = PROD_W'(s3_y_reg) * PROD_W'((s3_div_reg == DIV_5) ? RECIP_5 : RECIP_3);
        res_mean = (s3_div_reg == DIV_8) ? s3_mean8_reg : prod[RECIP_SH +: MEAN_W];
    end

    // Output register with skid
    assign pop = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (s3_valid_reg)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_mean_reg <= skid_mean_reg;
                out_row_reg  <= skid_row_reg;
                out_col_reg  <= skid_col_reg;
                out_last_reg <= skid_last_reg;
            end
        end
        else if (s3_valid_reg)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_mean_reg <= res_mean;
                skid_row_reg  <= s3_row_reg;
                skid_col_reg  <= s3_col_reg;
                skid_last_reg <= s3_last_reg;
            end
            else
            begin
                out_mean_reg <= res_mean;
                out_row_reg  <= s3_row_reg;
                out_col_reg  <= s3_col_reg;
                out_last_reg <= s3_last_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign mean_q8   = out_mean_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign last      = out_last_reg;

    // Checks
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item while the output register is empty");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg < column_count_reg)
        else $error("input column counter beyond column_count");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= (ROW_W'(row_count_reg) + ROW_W'(1)))
        else $error("input row counter beyond the drain row");

    a_drain_end_col: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg > ROW_W'(row_count_reg)) |-> (col_reg == '0))
        else $error("drain passed the final result position");

endmodule

[tb/tb.sv]
module tb;
    import nmf_pkg::*;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;
    localparam int REG_ROW_COUNT    = 0;
    localparam int REG_COLUMN_COUNT = 1;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE_CYCLES = 10;
    localparam int LONG_HOLD    = 80;
    localparam int RANDOM_ITEMS = 850;

    typedef struct {
        logic                         op;
        logic signed [PIXEL_BITS-1:0] pix;
    } item_t;

    typedef struct packed {
        logic signed [MEAN_W-1:0] mean;
        logic [POS_W-1:0]         row;
        logic [POS_W-1:0]         col;
        logic                     last;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic op = OP_PIXEL;
    logic signed [PIXEL_BITS-1:0] pixel = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [MEAN_W-1:0] mean_q8;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic last;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    neighbour_mean_3x3_filter uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .op(op), .pixel(pixel),
        .out_valid(out_valid), .out_ready(out_ready), .mean_q8(mean_q8),
        .out_row(out_row), .out_col(out_col), .last(last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Free-running clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Raster state mirrored from the block
    int unsigned rows_cfg = 2;
    int unsigned cols_cfg = 2;
    int unsigned raster_row = 0;
    int unsigned raster_col = 0;
    logic signed [PIXEL_BITS-1:0] upper_line [0:MAX_COLS_DEF-1];
    logic signed [PIXEL_BITS-1:0] middle_line [0:MAX_COLS_DEF-1];
    longint window_px [0:2][0:2];
    longint view_px [0:2][0:2];

    item_t   pixel_stream [$];
    result_t pending_means [$];
    item_t   next_item;
    result_t seen_mean;

    bit idle_on = 1'b1;
    int send_gap = 0;
    int take_gap = 0;
    int hold_asked = 0;
    int hold_taken = 0;
    int hold_left = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int random_items = 0;

    // Floored mean of the neighbors of (orow, ocol) that lie inside the matrix
    function automatic logic [MEAN_W-1:0] mean_of_view(int unsigned orow, int unsigned ocol);
        longint sum;
        longint cnt;
        longint q;
        longint r;
        longint c;
        sum = 0;
        cnt = 0;
        for (int dr = 0; dr < 3; dr++)
            for (int dc = 0; dc < 3; dc++)
            begin
                r = longint'(orow) + dr - 1;
                c = longint'(ocol) + dc - 1;
                if (!(dr == 1 && dc == 1) && r >= 0 && r < rows_cfg && c >= 0 && c < cols_cfg)
                begin
                    sum += view_px[dr][dc];
                    cnt++;
                end
            end
        if (cnt == 0)
            return '0;
        sum = sum * 256;
        q = sum / cnt;
        if (sum % cnt != 0 && sum < 0)
            q -= 1;
        if (q > 8388607)
            q = 8388607;
        if (q < -8388608)
            q = -8388608;
        return q[MEAN_W-1:0];
    endfunction

    // Advance the raster by one accepted item and queue the result it completes
    function automatic void advance_raster(logic drain, logic signed [PIXEL_BITS-1:0] pix);
        longint val;
        int unsigned ir;
        int unsigned ic;
        int unsigned orow;
        int unsigned ocol;
        int unsigned slot;
        logic emit;
        logic [MEAN_W-1:0] m;
        result_t res;
        ir = raster_row;
        ic = raster_col;
        orow = 0;
        ocol = 0;
        emit = 1'b0;
        m = '0;
        val = 0;
        if (!drain)
            val = pix;
        // drop pixels past the matrix end and drains before it
        if (!drain && ir >= rows_cfg)
            return;
        if (drain && ir < rows_cfg)
            return;
        // right column of two rows up, from the window before the shift
        if (ic == 0 && ir >= 2)
        begin
            orow = ir - 2;
            ocol = cols_cfg - 1;
            for (int r = 0; r < 3; r++)
            begin
                view_px[r][0] = window_px[r][1];
                view_px[r][1] = window_px[r][2];
                view_px[r][2] = 0;
            end
            m = mean_of_view(orow, ocol);
            emit = 1'b1;
        end
        // shift the window and rotate the line stores
        slot = ic % MAX_COLS_DEF;
        for (int r = 0; r < 3; r++)
        begin
            window_px[r][0] = window_px[r][1];
            window_px[r][1] = window_px[r][2];
        end
        window_px[0][2] = upper_line[slot];
        window_px[1][2] = middle_line[slot];
        window_px[2][2] = val;
        upper_line[slot] = middle_line[slot];
        middle_line[slot] = val[PIXEL_BITS-1:0];
        if (ic >= 1 && ir >= 1)
        begin
            orow = ir - 1;
            ocol = ic - 1;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    view_px[r][c] = window_px[r][c];
            m = mean_of_view(orow, ocol);
            emit = 1'b1;
        end
        ic++;
        if (ic >= cols_cfg)
        begin
            ic = 0;
            ir++;
        end
        raster_row = ir;
        raster_col = ic;
        if (!emit)
            return;
        res.mean = m;
        res.row = orow[POS_W-1:0];
        res.col = ocol[POS_W-1:0];
        res.last = (orow == rows_cfg - 1 && ocol == cols_cfg - 1);
        if (res.last)
        begin
            raster_row = 0;
            raster_col = 0;
        end
        pending_means.push_back(res);
    endfunction

    // Register write as the block sees it: clamp and restart the matrix
    function automatic void apply_register(int idx, logic [31:0] value);
        int unsigned v;
        v = value & 32'h7FF;
        if (v < 2)
            v = 2;
        if (v > 1024)
            v = 1024;
        if (idx == REG_ROW_COUNT)
            rows_cfg = v;
        else if (idx == REG_COLUMN_COUNT)
            cols_cfg = v;
        else
            return;
        raster_row = 0;
        raster_col = 0;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        mismatch_count++;
    endtask

    // Driver: offer queued items, with random gaps
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            advance_raster(op, pixel);
        if (!in_valid || in_ready)
        begin
            if (!rst_n || send_gap > 0 || pixel_stream.size() == 0)
            begin
                if (send_gap > 0)
                    send_gap--;
                in_valid <= 1'b0;
            end
            else
            begin
                next_item = pixel_stream.pop_front();
                in_valid <= 1'b1;
                op <= next_item.op;
                pixel <= next_item.pix;
                if (idle_on && $urandom_range(0, 7) == 0)
                    send_gap = $urandom_range(1, 4);
            end
        end
    end

    // Receiver: random stalls plus an occasional long hold
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (hold_asked != hold_taken)
        begin
            hold_taken = hold_asked;
            hold_left = LONG_HOLD;
            out_ready <= 1'b0;
        end
        else if (take_gap > 0)
        begin
            take_gap--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 5) == 0)
                take_gap = $urandom_range(1, 4);
        end
    end

    // Monitor: check each result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_means.size() == 0)
                report_mismatch("result with none expected, row", out_row, -1);
            else
            begin
                seen_mean = pending_means.pop_front();
                if (mean_q8 !== seen_mean.mean)
                    report_mismatch($sformatf("mean_q8 at (%0d,%0d)", seen_mean.row,
                                    seen_mean.col), mean_q8, seen_mean.mean);
                if (out_row !== seen_mean.row)
                    report_mismatch("out_row", out_row, seen_mean.row);
                if (out_col !== seen_mean.col)
                    report_mismatch("out_col", out_col, seen_mean.col);
                if (last !== seen_mean.last)
                    report_mismatch($sformatf("last at (%0d,%0d)", seen_mean.row,
                                    seen_mean.col), last, seen_mean.last);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_register(int idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(idx * 4);
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        apply_register(idx, value);
        @(negedge clk);
    endtask

    function automatic void push_item(logic item_op, logic signed [PIXEL_BITS-1:0] pix);
        item_t it;
        it.op = item_op;
        it.pix = pix;
        pixel_stream.push_back(it);
        random_items++;
    endfunction

    function automatic logic signed [PIXEL_BITS-1:0] pick_pixel(int mode);
        case (mode)
            1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            2: return PIXEL_BITS'($signed($urandom_range(0, 6)) - 3);
            default: return PIXEL_BITS'($urandom);
        endcase
    endfunction

    // Full matrix plus drains; noisy matrices add items the block must drop
    function automatic void push_matrix(int mode, bit noisy);
        int unsigned n;
        n = rows_cfg * cols_cfg;
        for (int unsigned i = 0; i < n; i++)
        begin
            if (noisy && $urandom_range(0, 9) == 0)
                push_item(OP_DRAIN, pick_pixel(0));
            push_item(OP_PIXEL, pick_pixel(mode));
        end
        for (int unsigned i = 0; i <= cols_cfg; i++)
        begin
            if (noisy && $urandom_range(0, 9) == 0)
                push_item(OP_PIXEL, pick_pixel(0));
            push_item(OP_DRAIN, pick_pixel(0));
        end
    endfunction

    // Hold the sender until every item is taken and every result is back
    task automatic settle();
        @(negedge clk);
        while (pixel_stream.size() != 0 || in_valid || pending_means.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic [31:0] rows_w;
        logic [31:0] cols_w;
        bit wrote_rows;
        int phase;
        int n_mat;
        int unsigned part;

        for (int i = 0; i < MAX_COLS_DEF; i++)
        begin
            upper_line[i] = '0;
            middle_line[i] = '0;
        end
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
            begin
                window_px[r][c] = 0;
                view_px[r][c] = 0;
            end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: 2x2 from reset with extremes, early drain, late pixel
        push_item(OP_DRAIN, 16'sh1234);
        push_item(OP_PIXEL, 16'sh7FFF);
        push_item(OP_PIXEL, 16'sh8000);
        push_item(OP_PIXEL, 16'sh8000);
        push_item(OP_PIXEL, 16'sh7FFF);
        push_item(OP_PIXEL, 16'sh007B);
        repeat (3) push_item(OP_DRAIN, 16'shFFFF);
        settle();

        // Directed: 3x3 covers corner, edge and interior, floor of negatives
        write_register(REG_ROW_COUNT, 32'd3);
        write_register(REG_COLUMN_COUNT, 32'd3);
        push_item(OP_PIXEL, -16'sd1);
        push_item(OP_PIXEL, 16'sd0);
        push_item(OP_PIXEL, 16'sd0);
        push_item(OP_PIXEL, 16'sd0);
        push_item(OP_PIXEL, 16'sh7FFF);
        push_item(OP_PIXEL, 16'sh8000);
        push_item(OP_PIXEL, 16'sd1);
        push_item(OP_PIXEL, 16'sh8000);
        push_item(OP_PIXEL, 16'sh7FFF);
        repeat (4) push_item(OP_DRAIN, 16'sd0);
        settle();

        // Random phases: mostly small matrices, clamped and garbage-bit writes
        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            phase++;
            idle_on = (phase % 4 != 0);
            rows_w = $urandom_range(0, 6);
            cols_w = $urandom_range(0, 8);
            if ($urandom_range(0, 9) == 0)
                cols_w = $urandom_range(9, 40);
            if ($urandom_range(0, 3) == 0)
                rows_w[31:11] = 21'($urandom);
            if ($urandom_range(0, 3) == 0)
                cols_w[31:11] = 21'($urandom);
            if (phase == 2)
            begin
                rows_w = 8;
                cols_w = 8;
            end
            wrote_rows = 1'b0;
            if (phase == 2 || $urandom_range(0, 3) != 0)
            begin
                write_register(REG_ROW_COUNT, rows_w);
                wrote_rows = 1'b1;
            end
            if (!wrote_rows || $urandom_range(0, 3) != 0)
                write_register(REG_COLUMN_COUNT, cols_w);
            // long receiver hold while the sender keeps offering
            if (phase == 2)
                hold_asked++;
            n_mat = $urandom_range(1, 3);
            for (int m = 0; m < n_mat; m++)
                push_matrix($urandom_range(0, 5) < 3 ? 0 : $urandom_range(1, 2),
                            $urandom_range(0, 3) == 0);
            // broken sequence: a truncated matrix, restarted by the next write
            if ($urandom_range(0, 5) == 0)
            begin
                part = $urandom_range(1, rows_cfg * cols_cfg - 1);
                for (int unsigned i = 0; i < part; i++)
                    push_item(OP_PIXEL, pick_pixel(0));
                settle();
                write_register(REG_COLUMN_COUNT, cols_cfg);
            end
            settle();
        end

        // Last stretch at full rate on both sides
        idle_on = 1'b0;
        write_register(REG_ROW_COUNT, $urandom_range(3, 6));
        write_register(REG_COLUMN_COUNT, $urandom_range(3, 8));
        push_matrix(0, 1'b0);
        push_matrix(1, 1'b0);
        settle();

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
rtl/nmf_pkg.sv
rtl/nmf_ram.sv
rtl/neighbour_mean_3x3_filter.sv
tb/tb.sv
